FILE: sv/dpe_pkg.sv
package dpe_pkg;

	localparam int DATA_W   = 32;
	localparam int WIDE_W   = 64;
	localparam int STEP_W   = 24;
	localparam int GAIN_W   = 31;
	localparam int ADDR_W   = 5;
	localparam int STEP_FRAC = 24;

	localparam int FRACTION_BITS_DEF = 24;
	localparam int CORDIC_STEPS_DEF  = 24;

	// CORDIC datapath: Q2.30 values with headroom for the angle wrap
	localparam int CW       = 35;
	localparam int ATAN_LEN = 30;
	localparam int ATAN_W   = 30;
	localparam int CNT_W    = $clog2(ATAN_LEN);

	localparam logic signed [CW-1:0] Q30_PI      = 35'sd3373259426;
	localparam logic signed [CW-1:0] Q30_TWO_PI  = 35'sd6746518852;
	localparam logic signed [CW-1:0] Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [CW-1:0] Q30_GAIN    = 35'sd652032874;

	localparam logic signed [WIDE_W-1:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [WIDE_W-1:0] SAT_LO = -64'sd2147483648;

	localparam logic [STEP_W-1:0] STEP_TIME_RST    = 24'd16777;
	localparam logic [GAIN_W-1:0] GRAVITY_GAIN_RST = 31'd1006632960;
	localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST   = 31'd100663296;
	localparam logic [GAIN_W-1:0] DAMPING_GAIN_RST = 31'd0;
	localparam logic [DATA_W-1:0] INIT_ANGLE_RST   = 32'd0;

	typedef enum logic [2:0] {
		REG_STEP_TIME,
		REG_GRAVITY_GAIN,
		REG_ACCEL_GAIN,
		REG_DAMPING_GAIN,
		REG_INIT_ANGLE
	} reg_idx_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_time;
		logic [GAIN_W-1:0] gravity_gain;
		logic [GAIN_W-1:0] accel_gain;
		logic [GAIN_W-1:0] damping_gain;
		logic [DATA_W-1:0] initial_angle;
	} cfg_t;

	typedef struct packed {
		logic              go;
		logic              dt;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] res;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] angle;
	} cdc_req_t;

	typedef struct packed {
		logic              busy;
		logic [DATA_W-1:0] sin;
		logic [DATA_W-1:0] cos;
	} cdc_rsp_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_MOD,
		C_WRAP,
		C_FOLD,
		C_ROT,
		C_OUT
	} cdc_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_DAMP,
		S_DA,
		S_WAIT_SC,
		S_GRAV,
		S_ACOS,
		S_ALPHA,
		S_DV,
		S_UPD
	} seq_state_t;

	function automatic logic [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		if (v > SAT_HI) return DATA_W'(SAT_HI);
		if (v < SAT_LO) return DATA_W'(SAT_LO);
		return DATA_W'(v);
	endfunction

	// arctangent of 2^-i in Q2.30, truncated
	function automatic logic [ATAN_W-1:0] atan_q30(input logic [CNT_W-1:0] i);
		logic [ATAN_W-1:0] r;
		case (i)
			5'd0:  r = 30'h3243F6A8;
			5'd1:  r = 30'h1DAC6705;
			5'd2:  r = 30'h0FADBAFC;
			5'd3:  r = 30'h07F56EA6;
			5'd4:  r = 30'h03FEAB76;
			5'd5:  r = 30'h01FFD55B;
			5'd6:  r = 30'h00FFFAAA;
			5'd7:  r = 30'h007FFF55;
			5'd8:  r = 30'h003FFFEA;
			5'd9:  r = 30'h001FFFFD;
			5'd10: r = 30'h000FFFFF;
			5'd11: r = 30'h0007FFFF;
			5'd12: r = 30'h0003FFFF;
			5'd13: r = 30'h0001FFFF;
			5'd14: r = 30'h0000FFFF;
			5'd15: r = 30'h00007FFF;
			5'd16: r = 30'h00003FFF;
			5'd17: r = 30'h00001FFF;
			5'd18: r = 30'h00000FFF;
			5'd19: r = 30'h000007FF;
			5'd20: r = 30'h000003FF;
			5'd21: r = 30'h000001FF;
			5'd22: r = 30'h000000FF;
			5'd23: r = 30'h0000007F;
			5'd24: r = 30'h0000003F;
			5'd25: r = 30'h0000001F;
			5'd26: r = 30'h0000000F;
			5'd27: r = 30'h00000007;
			5'd28: r = 30'h00000003;
			5'd29: r = 30'h00000001;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/dpe_in_if.sv
interface dpe_in_if import dpe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] cart_accel;

	modport source(output valid, output cart_accel, input ready);
	modport sink(input valid, input cart_accel, output ready);
endinterface

FILE: sv/dpe_out_if.sv
interface dpe_out_if import dpe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] pole_angle;
	logic [DATA_W-1:0] pole_rate;

	modport source(output valid, output pole_angle, output pole_rate, input ready);
	modport sink(input valid, input pole_angle, input pole_rate, output ready);
endinterface

FILE: sv/dpe_regs.sv
module dpe_regs import dpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg,
	output logic              angle_load,
	output logic [DATA_W-1:0] angle_init
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;
	assign angle_load = wr && (idx == REG_INIT_ANGLE);
	// the written value itself, so the angle state loads on the same edge
	assign angle_init = pwdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_time     <= STEP_TIME_RST;
			cfg_q.gravity_gain  <= GRAVITY_GAIN_RST;
			cfg_q.accel_gain    <= ACCEL_GAIN_RST;
			cfg_q.damping_gain  <= DAMPING_GAIN_RST;
			cfg_q.initial_angle <= INIT_ANGLE_RST;
		end else if (wr) begin
			unique case (idx)
				REG_STEP_TIME:    cfg_q.step_time     <= pwdata[STEP_W-1:0];
				REG_GRAVITY_GAIN: cfg_q.gravity_gain  <= pwdata[GAIN_W-1:0];
				REG_ACCEL_GAIN:   cfg_q.accel_gain    <= pwdata[GAIN_W-1:0];
				REG_DAMPING_GAIN: cfg_q.damping_gain  <= pwdata[GAIN_W-1:0];
				REG_INIT_ANGLE:   cfg_q.initial_angle <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_STEP_TIME:    prdata = DATA_W'(cfg_q.step_time);
			REG_GRAVITY_GAIN: prdata = DATA_W'(cfg_q.gravity_gain);
			REG_ACCEL_GAIN:   prdata = DATA_W'(cfg_q.accel_gain);
			REG_DAMPING_GAIN: prdata = DATA_W'(cfg_q.damping_gain);
			REG_INIT_ANGLE:   prdata = cfg_q.initial_angle;
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: sv/dpe_mul.sv
module dpe_mul import dpe_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam logic signed [WIDE_W-1:0] RND_F  = WIDE_W'(1) <<< (FRACTION_BITS - 1);
	localparam logic signed [WIDE_W-1:0] RND_DT = WIDE_W'(1) <<< (STEP_FRAC - 1);

	logic                     vld_s1, dt_s1, vld_q;
	logic signed [WIDE_W-1:0] prod_s1;
	logic signed [WIDE_W-1:0] sum, shifted;
	logic [DATA_W-1:0]        res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			vld_s1 <= req.go;
			vld_q  <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= WIDE_W'($signed(req.a)) * WIDE_W'($signed(req.b));
		dt_s1   <= req.dt;
		res_q   <= sat32(shifted);
	end

	// round half up, then drop the fraction bits of the product
	always_comb begin
		sum     = prod_s1 + (dt_s1 ? RND_DT : RND_F);
		shifted = dt_s1 ? (sum >>> STEP_FRAC) : (sum >>> FRACTION_BITS);
	end

	assign rsp.valid = vld_q;
	assign rsp.res   = res_q;

endmodule

FILE: sv/dpe_cordic.sv
module dpe_cordic import dpe_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cdc_req_t req,
	output cdc_rsp_t rsp
);

	localparam int SH        = 30 - FRACTION_BITS;
	localparam int R_W       = DATA_W + SH;
	localparam int MOD_STEPS = R_W - 31;
	localparam int TRIAL_W   = R_W + 1;
	localparam int NITER     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam logic [CNT_W-1:0] MOD_FIRST = CNT_W'(MOD_STEPS - 1);
	localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(NITER - 1);
	localparam logic [TRIAL_W-1:0] TRIAL_INIT = TRIAL_W'(Q30_TWO_PI) << (MOD_STEPS - 1);
	localparam logic signed [CW-1:0] RND = CW'((64'd1 << SH) >> 1);

	cdc_state_t state_q, state_d;

	logic [R_W-1:0]          mag_q;
	logic [TRIAL_W-1:0]      trial_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg_q, negc_q;
	logic signed [CW-1:0]    z_q, x_q, y_q;
	logic [DATA_W-1:0]       sin_q, cos_q;

	logic signed [R_W-1:0]   r_ext;
	logic [R_W-1:0]          mag_d;
	logic [TRIAL_W-1:0]      diff;
	logic                    ge;
	logic signed [CW-1:0]    rem_s, wrap_d, fold_z, xs, ys, at, x_fin, sin_d, cos_d;
	logic                    fold_n;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: if (req.start) state_d = C_MOD;
			C_MOD:  if (cnt_q == '0) state_d = C_WRAP;
			C_WRAP: state_d = C_FOLD;
			C_FOLD: state_d = C_ROT;
			C_ROT:  if (cnt_q == ROT_LAST) state_d = C_OUT;
			C_OUT:  state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	always_comb begin
		rsp.busy = (state_q != C_IDLE);
		rsp.sin  = sin_q;
		rsp.cos  = cos_q;
	end

	always_comb begin
		r_ext = R_W'($signed(req.angle)) <<< SH;
		mag_d = r_ext[R_W-1] ? R_W'(-r_ext) : R_W'(r_ext);
		diff  = {1'b0, mag_q} - trial_q;
		ge    = ({1'b0, mag_q} >= trial_q);

		// sign back on, then wrap into [-pi, pi]
		rem_s = $signed(CW'(mag_q));
		if (rem_s > Q30_PI)
			wrap_d = neg_q ? (Q30_TWO_PI - rem_s) : (rem_s - Q30_TWO_PI);
		else
			wrap_d = neg_q ? -rem_s : rem_s;

		// fold into [-pi/2, pi/2]; cosine changes sign
		fold_n = 1'b1;
		if (z_q > Q30_HALF_PI)
			fold_z = Q30_PI - z_q;
		else if (z_q < -Q30_HALF_PI)
			fold_z = -Q30_PI - z_q;
		else begin
			fold_z = z_q;
			fold_n = 1'b0;
		end

		xs    = x_q >>> cnt_q;
		ys    = y_q >>> cnt_q;
		at    = $signed(CW'(atan_q30(cnt_q)));
		x_fin = negc_q ? -x_q : x_q;
		sin_d = (y_q + RND) >>> SH;
		cos_d = (x_fin + RND) >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				C_IDLE: cnt_q <= MOD_FIRST;
				C_MOD:  cnt_q <= cnt_q - 1'b1;
				C_FOLD: cnt_q <= '0;
				C_ROT:  cnt_q <= cnt_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				mag_q   <= mag_d;
				neg_q   <= r_ext[R_W-1];
				trial_q <= TRIAL_INIT;
			end
			C_MOD: begin
				if (ge) mag_q <= diff[R_W-1:0];
				trial_q <= trial_q >> 1;
			end
			C_WRAP: z_q <= wrap_d;
			C_FOLD: begin
				z_q    <= fold_z;
				negc_q <= fold_n;
				x_q    <= Q30_GAIN;
				y_q    <= '0;
			end
			C_ROT: begin
				if (!z_q[CW-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
			end
			C_OUT: begin
				sin_q <= DATA_W'(sin_d);
				cos_q <= DATA_W'(cos_d);
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/dpe_seq.sv
module dpe_seq import dpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	dpe_in_if.sink            accel,
	dpe_out_if.source         pole,
	input  cfg_t              cfg,
	input  logic              angle_load,
	input  logic [DATA_W-1:0] angle_init,
	output mul_req_t          mul_req,
	input  mul_rsp_t          mul_rsp,
	output cdc_req_t          cdc_req,
	input  cdc_rsp_t          cdc_rsp
);

	seq_state_t state_q, state_d;

	logic              pend_q, out_vld_q;
	logic [DATA_W-1:0] angle_q, rate_q, accel_q;
	logic [DATA_W-1:0] amul_q, dterm_q, da_q, gterm_q, aterm_q, alpha_q, dv_q;
	logic [DATA_W-1:0] out_angle_q, out_rate_q;
	logic [DATA_W-1:0] alpha_d, angle_d, rate_d;
	logic              accept, is_mul, slot_free, post;

	assign accept    = accel.valid && accel.ready;
	assign slot_free = !out_vld_q || pole.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (accel.valid) state_d = S_ACC;
			S_ACC:     if (mul_rsp.valid) state_d = S_DAMP;
			S_DAMP:    if (mul_rsp.valid) state_d = S_DA;
			S_DA:      if (mul_rsp.valid) state_d = S_WAIT_SC;
			S_WAIT_SC: if (!cdc_rsp.busy) state_d = S_GRAV;
			S_GRAV:    if (mul_rsp.valid) state_d = S_ACOS;
			S_ACOS:    if (mul_rsp.valid) state_d = S_ALPHA;
			S_ALPHA:   state_d = S_DV;
			S_DV:      if (mul_rsp.valid) state_d = S_UPD;
			S_UPD:     if (slot_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		accel.ready   = (state_q == S_IDLE);
		cdc_req.start = accept;
		cdc_req.angle = angle_q;
		post          = (state_q == S_UPD) && slot_free;
		is_mul        = 1'b1;
		mul_req.dt    = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		unique case (state_q)
			S_ACC: begin
				mul_req.a = DATA_W'(cfg.accel_gain);
				mul_req.b = accel_q;
			end
			S_DAMP: begin
				mul_req.a = DATA_W'(cfg.damping_gain);
				mul_req.b = rate_q;
			end
			S_DA: begin
				mul_req.dt = 1'b1;
				mul_req.a  = DATA_W'(cfg.step_time);
				mul_req.b  = rate_q;
			end
			S_GRAV: begin
				mul_req.a = DATA_W'(cfg.gravity_gain);
				mul_req.b = cdc_rsp.sin;
			end
			S_ACOS: begin
				mul_req.a = amul_q;
				mul_req.b = cdc_rsp.cos;
			end
			S_DV: begin
				mul_req.dt = 1'b1;
				mul_req.a  = DATA_W'(cfg.step_time);
				mul_req.b  = alpha_q;
			end
			default: is_mul = 1'b0;
		endcase
		mul_req.go = is_mul && !pend_q;
	end

	always_comb begin
		alpha_d = sat32(WIDE_W'($signed(gterm_q)) - WIDE_W'($signed(aterm_q))
			- WIDE_W'($signed(dterm_q)));
		angle_d = sat32(WIDE_W'($signed(angle_q)) + WIDE_W'($signed(da_q)));
		rate_d  = sat32(WIDE_W'($signed(rate_q)) + WIDE_W'($signed(dv_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
			angle_q   <= INIT_ANGLE_RST;
			rate_q    <= '0;
		end else begin
			state_q <= state_d;
			if (mul_rsp.valid) pend_q <= 1'b0;
			else if (mul_req.go) pend_q <= 1'b1;
			if (post) out_vld_q <= 1'b1;
			else if (pole.ready) out_vld_q <= 1'b0;
			if (angle_load) angle_q <= angle_init;
			else if (post) begin
				angle_q <= angle_d;
				rate_q  <= rate_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) accel_q <= accel.cart_accel;
		if (mul_rsp.valid) begin
			case (state_q)
				S_ACC:  amul_q  <= mul_rsp.res;
				S_DAMP: dterm_q <= mul_rsp.res;
				S_DA:   da_q    <= mul_rsp.res;
				S_GRAV: gterm_q <= mul_rsp.res;
				S_ACOS: aterm_q <= mul_rsp.res;
				S_DV:   dv_q    <= mul_rsp.res;
				default: ;
			endcase
		end
		if (state_q == S_ALPHA) alpha_q <= alpha_d;
		if (post) begin
			out_angle_q <= angle_d;
			out_rate_q  <= rate_d;
		end
	end

	assign pole.valid      = out_vld_q;
	assign pole.pole_angle = out_angle_q;
	assign pole.pole_rate  = out_rate_q;

endmodule

FILE: sv/damped_pendulum_euler_step.sv
// Pole-on-cart integrator: every accepted accel beat advances the kept pole angle and
// rate by one forward Euler step, alpha = G*sin(angle) - A*accel*cos(angle) - D*rate,
// angle += dt*rate_old, rate += dt*alpha, all signed Q8.24 (FRACTION_BITS) and
// saturated, and the new angle and rate leave as one beat on the pole channel. Gains
// and dt sit in APB registers at byte offsets 0x00 step_time, 0x04 gravity_gain,
// 0x08 accel_gain, 0x0C damping_gain, 0x10 initial_angle; writing initial_angle also
// loads the kept angle. The user must write registers only while the block is idle;
// the block itself does not enforce this. One beat is worked at a time, its time set
// mainly by the CORDIC unit, with one compare-subtract per cycle for the modulo-2*pi
// reduction and one rotation per cycle, followed by the three multiplies that need
// sin, cos and alpha on the one shared 32x32 multiplier. The next accel beat is taken
// as soon as the result sits in the output register, even while that result waits to
// be taken.
module damped_pendulum_euler_step import dpe_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	dpe_in_if.sink            accel,
	dpe_out_if.source         pole
);

	cfg_t              cfg;
	logic              angle_load;
	logic [DATA_W-1:0] angle_init;
	mul_req_t          mul_req;
	mul_rsp_t          mul_rsp;
	cdc_req_t          cdc_req;
	cdc_rsp_t          cdc_rsp;

	// register file; a write to initial_angle also reloads the angle state
	dpe_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cfg        (cfg),
		.angle_load (angle_load),
		.angle_init (angle_init)
	);

	// sin/cos of the current angle, started on the accept edge and run alongside
	// the multiplies that do not need it
	dpe_cordic #(
		.FRACTION_BITS (FRACTION_BITS),
		.CORDIC_STEPS  (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cdc_req),
		.rsp    (cdc_rsp)
	);

	// shared multiplier: product register, then round half up and saturate
	dpe_mul #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// sequencer: holds angle/rate state, orders the six multiplies, posts the result
	dpe_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.accel      (accel),
		.pole       (pole),
		.cfg        (cfg),
		.angle_load (angle_load),
		.angle_init (angle_init),
		.mul_req    (mul_req),
		.mul_rsp    (mul_rsp),
		.cdc_req    (cdc_req),
		.cdc_rsp    (cdc_rsp)
	);

endmodule
